### rtl/blca_pkg.sv
// Package for the binary-lifting LCA engine: table geometry, request codes,
// sequencer states, memory request structs and the ancestor address helper.
// No dependencies.
package blca_pkg;

    localparam int NODE_W      = 10;
    localparam int NODE_COUNT  = 1 << NODE_W;
    localparam int LEVELS      = 10;
    localparam int LVL_W       = $clog2(LEVELS);
    localparam int DEP_W       = 10;
    localparam int ANC_DEPTH   = NODE_COUNT * LEVELS;
    localparam int ANC_AW      = $clog2(ANC_DEPTH);

    typedef enum logic {
        REQ_ATTACH = 1'b0,
        REQ_QUERY  = 1'b1
    } t_req;

    typedef enum logic [15:0] {
        S_CLEAR = 16'b0000_0000_0000_0001,
        S_IDLE  = 16'b0000_0000_0000_0010,
        S_START = 16'b0000_0000_0000_0100,
        S_A_DEP = 16'b0000_0000_0000_1000,
        S_A_WR  = 16'b0000_0000_0001_0000,
        S_A_RD  = 16'b0000_0000_0010_0000,
        S_Q_DB  = 16'b0000_0000_0100_0000,
        S_Q_CMP = 16'b0000_0000_1000_0000,
        S_Q_L1  = 16'b0000_0001_0000_0000,
        S_Q_L1W = 16'b0000_0010_0000_0000,
        S_Q_EQ  = 16'b0000_0100_0000_0000,
        S_Q_L2A = 16'b0000_1000_0000_0000,
        S_Q_L2B = 16'b0001_0000_0000_0000,
        S_Q_L2C = 16'b0010_0000_0000_0000,
        S_Q_FIN = 16'b0100_0000_0000_0000,
        S_DONE  = 16'b1000_0000_0000_0000
    } t_state;

    typedef struct packed {
        logic              we;
        logic [ANC_AW-1:0] waddr;
        logic [NODE_W-1:0] wdata;
        logic              re;
        logic [ANC_AW-1:0] raddr;
    } t_anc_req;

    typedef struct packed {
        logic              we;
        logic [NODE_W-1:0] waddr;
        logic [DEP_W-1:0]  wdata;
        logic              re;
        logic [NODE_W-1:0] raddr;
    } t_dep_req;

    // row-major: node * LEVELS + level (constant multiply)
    function automatic logic [ANC_AW-1:0] anc_addr(input logic [NODE_W-1:0] node,
                                                   input logic [LVL_W-1:0]  lvl);
        anc_addr = ANC_AW'(node) * ANC_AW'(LEVELS) + ANC_AW'(lvl);
    endfunction

endpackage

### rtl/blca_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module blca_ram #(
    parameter int WIDTH = 10,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

### rtl/blca_core.sv
// Sequencer for the LCA engine: clearing pass, attach row build, query lifts.
// Depends on blca_pkg; drives the ancestor and depth RAMs through request structs.
module blca_core
    import blca_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  logic              i_req_type,
    input  logic [NODE_W-1:0] i_node_a,
    input  logic [NODE_W-1:0] i_node_b,
    output t_anc_req          o_anc_req,
    input  logic [NODE_W-1:0] i_anc_rdata,
    output t_dep_req          o_dep_req,
    input  logic [DEP_W-1:0]  i_dep_rdata,
    output logic              o_res_valid,
    output logic [NODE_W-1:0] o_res_data,
    input  logic              i_res_take
);

    t_state            r_state, n_state;
    logic [ANC_AW-1:0] r_clr, n_clr;
    logic              r_query, n_query;
    logic [NODE_W-1:0] r_a, n_a;
    logic [NODE_W-1:0] r_b, n_b;
    logic [NODE_W-1:0] r_cur, n_cur;
    logic [NODE_W-1:0] r_pa, n_pa;
    logic [NODE_W-1:0] r_res, n_res;
    logic [LVL_W-1:0]  r_k, n_k;
    logic [DEP_W-1:0]  r_da, n_da;
    logic [DEP_W-1:0]  r_diff, n_diff;

    logic [NODE_W-1:0] l2_a, l2_b;
    logic [DEP_W-1:0]  dep_inc;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_clr   <= '0;
        end else begin
            r_state <= n_state;
            r_clr   <= n_clr;
        end
    end

    always_ff @(posedge i_clk) begin
        r_query <= n_query;
        r_a     <= n_a;
        r_b     <= n_b;
        r_cur   <= n_cur;
        r_pa    <= n_pa;
        r_res   <= n_res;
        r_k     <= n_k;
        r_da    <= n_da;
        r_diff  <= n_diff;
    end

    // second lift: step both nodes when their ancestors differ
    assign l2_a = (r_pa != i_anc_rdata) ? r_pa : r_a;
    assign l2_b = (r_pa != i_anc_rdata) ? i_anc_rdata : r_b;

    // parent depth plus one, saturating at the top node number
    assign dep_inc = (i_dep_rdata < DEP_W'(NODE_COUNT - 1)) ? i_dep_rdata + DEP_W'(1)
                                                            : i_dep_rdata;

    always_comb begin
        n_state   = r_state;
        n_clr     = r_clr;
        n_query   = r_query;
        n_a       = r_a;
        n_b       = r_b;
        n_cur     = r_cur;
        n_pa      = r_pa;
        n_res     = r_res;
        n_k       = r_k;
        n_da      = r_da;
        n_diff    = r_diff;
        o_anc_req = '0;
        o_dep_req = '0;

        case (r_state)
            S_CLEAR: begin
                o_anc_req.we    = 1'b1;
                o_anc_req.waddr = r_clr;
                o_anc_req.wdata = '0;
                o_dep_req.we    = (r_clr < ANC_AW'(NODE_COUNT));
                o_dep_req.waddr = r_clr[NODE_W-1:0];
                o_dep_req.wdata = '0;
                n_clr           = r_clr + ANC_AW'(1);
                if (r_clr == ANC_AW'(ANC_DEPTH - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_in_valid) begin
                    n_query = (i_req_type == REQ_QUERY);
                    n_a     = i_node_a;
                    n_b     = i_node_b;
                    n_state = S_START;
                end
            end
            S_START: begin
                if (r_query) begin
                    o_dep_req.re    = 1'b1;
                    o_dep_req.raddr = r_a;
                    n_state         = S_Q_DB;
                end else if (r_a == '0) begin
                    // sentinel row is never overwritten
                    n_state = S_IDLE;
                end else begin
                    o_anc_req.we    = 1'b1;
                    o_anc_req.waddr = anc_addr(r_a, '0);
                    o_anc_req.wdata = r_b;
                    o_dep_req.re    = 1'b1;
                    o_dep_req.raddr = r_b;
                    n_cur           = r_b;
                    n_k             = LVL_W'(1);
                    n_state         = S_A_DEP;
                end
            end
            S_A_DEP: begin
                o_dep_req.we    = 1'b1;
                o_dep_req.waddr = r_a;
                o_dep_req.wdata = (r_b == '0) ? '0 : dep_inc;
                o_anc_req.re    = 1'b1;
                o_anc_req.raddr = anc_addr(r_cur, r_k - LVL_W'(1));
                n_state         = S_A_WR;
            end
            S_A_WR: begin
                o_anc_req.we    = 1'b1;
                o_anc_req.waddr = anc_addr(r_a, r_k);
                o_anc_req.wdata = i_anc_rdata;
                n_cur           = i_anc_rdata;
                if (r_k == LVL_W'(LEVELS - 1)) begin
                    n_state = S_IDLE;
                end else begin
                    n_k     = r_k + LVL_W'(1);
                    n_state = S_A_RD;
                end
            end
            S_A_RD: begin
                // issued the cycle after the write, so a self-referencing row reads fresh data
                o_anc_req.re    = 1'b1;
                o_anc_req.raddr = anc_addr(r_cur, r_k - LVL_W'(1));
                n_state         = S_A_WR;
            end
            S_Q_DB: begin
                n_da            = i_dep_rdata;
                o_dep_req.re    = 1'b1;
                o_dep_req.raddr = r_b;
                n_state         = S_Q_CMP;
            end
            S_Q_CMP: begin
                if (r_da < i_dep_rdata) begin
                    n_a    = r_b;
                    n_b    = r_a;
                    n_diff = i_dep_rdata - r_da;
                end else begin
                    n_diff = r_da - i_dep_rdata;
                end
                n_k     = LVL_W'(LEVELS - 1);
                n_state = S_Q_L1;
            end
            S_Q_L1: begin
                if (r_diff[r_k]) begin
                    o_anc_req.re    = 1'b1;
                    o_anc_req.raddr = anc_addr(r_a, r_k);
                    n_state         = S_Q_L1W;
                end else if (r_k == '0) begin
                    n_state = S_Q_EQ;
                end else begin
                    n_k = r_k - LVL_W'(1);
                end
            end
            S_Q_L1W: begin
                n_a = i_anc_rdata;
                if (r_k == '0) begin
                    n_state = S_Q_EQ;
                end else begin
                    n_k     = r_k - LVL_W'(1);
                    n_state = S_Q_L1;
                end
            end
            S_Q_EQ: begin
                if (r_a == r_b) begin
                    n_res   = r_a;
                    n_state = S_DONE;
                end else begin
                    n_k     = LVL_W'(LEVELS - 1);
                    n_state = S_Q_L2A;
                end
            end
            S_Q_L2A: begin
                o_anc_req.re    = 1'b1;
                o_anc_req.raddr = anc_addr(r_a, r_k);
                n_state         = S_Q_L2B;
            end
            S_Q_L2B: begin
                n_pa            = i_anc_rdata;
                o_anc_req.re    = 1'b1;
                o_anc_req.raddr = anc_addr(r_b, r_k);
                n_state         = S_Q_L2C;
            end
            S_Q_L2C: begin
                n_a          = l2_a;
                n_b          = l2_b;
                o_anc_req.re = 1'b1;
                if (r_k == '0) begin
                    // parent of the final a is the answer
                    o_anc_req.raddr = anc_addr(l2_a, '0);
                    n_state         = S_Q_FIN;
                end else begin
                    o_anc_req.raddr = anc_addr(l2_a, r_k - LVL_W'(1));
                    n_k             = r_k - LVL_W'(1);
                    n_state         = S_Q_L2B;
                end
            end
            S_Q_FIN: begin
                n_res   = i_anc_rdata;
                n_state = S_DONE;
            end
            S_DONE: begin
                if (i_res_take) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_res_valid = (r_state == S_DONE);
    assign o_res_data  = r_res;

endmodule

### rtl/binary_lifting_lca_engine.sv
// LCA engine: attach builds the node's ancestor row (node 0 is ignored); a query lifts
// to equal depth, then lifts both nodes unless they already meet. Pace set by one ancestor-RAM read port.
// One transaction in flight; the result register lets the next request enter
// while a result waits. After reset a clearing pass zeroes both tables, and
// in_ready stays low meanwhile. Reset is synchronous, active low.
module binary_lifting_lca_engine
    import blca_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  logic              i_req_type,
    input  logic [NODE_W-1:0] i_node_a,
    input  logic [NODE_W-1:0] i_node_b,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output logic [NODE_W-1:0] o_common_ancestor
);

    // Ancestor table: row per node, LEVELS entries per row, 2^k-th ancestor.
    // Depth table: one entry per node. Both sit in single-read-port RAMs and the
    // sequencer issues reads the cycle after writes to the same row.

    t_anc_req          anc_req;
    t_dep_req          dep_req;
    logic [NODE_W-1:0] anc_rdata;
    logic [DEP_W-1:0]  dep_rdata;

    logic              res_valid;
    logic [NODE_W-1:0] res_data;
    logic              res_take;
    logic              slot_free;

    logic              r_out_valid;
    logic [NODE_W-1:0] r_out_data;

    blca_ram #(
        .WIDTH (NODE_W),
        .DEPTH (ANC_DEPTH)
    ) u_anc_ram (
        .i_clk   (i_clk),
        .i_we    (anc_req.we),
        .i_waddr (anc_req.waddr),
        .i_wdata (anc_req.wdata),
        .i_re    (anc_req.re),
        .i_raddr (anc_req.raddr),
        .o_rdata (anc_rdata)
    );

    blca_ram #(
        .WIDTH (DEP_W),
        .DEPTH (NODE_COUNT)
    ) u_dep_ram (
        .i_clk   (i_clk),
        .i_we    (dep_req.we),
        .i_waddr (dep_req.waddr),
        .i_wdata (dep_req.wdata),
        .i_re    (dep_req.re),
        .i_raddr (dep_req.raddr),
        .o_rdata (dep_rdata)
    );

    blca_core u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_req_type  (i_req_type),
        .i_node_a    (i_node_a),
        .i_node_b    (i_node_b),
        .o_anc_req   (anc_req),
        .i_anc_rdata (anc_rdata),
        .o_dep_req   (dep_req),
        .i_dep_rdata (dep_rdata),
        .o_res_valid (res_valid),
        .o_res_data  (res_data),
        .i_res_take  (res_take)
    );

    // output register: free when empty or being drained this cycle
    assign slot_free = !r_out_valid || i_out_ready;
    assign res_take  = res_valid && slot_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (res_take) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_take) begin
            r_out_data <= res_data;
        end
    end

    assign o_out_valid       = r_out_valid;
    assign o_common_ancestor = r_out_data;

endmodule

### rtl/blca_checker.sv
// Port-level checks for the LCA engine, bound to the top level.
// Depends on blca_pkg for field widths.
module blca_checker
    import blca_pkg::*;
(
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              i_in_valid,
    input logic              o_in_ready,
    input logic              o_out_valid,
    input logic              i_out_ready,
    input logic [NODE_W-1:0] o_common_ancestor
);

    // a held result keeps its value until taken
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_common_ancestor))
        else $error("result dropped or changed while stalled");

    // reset starts the clearing pass: nothing accepted, nothing shown
    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_in_ready && !o_out_valid)
        else $error("engine active right after reset");

    // one transaction at a time
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> !o_in_ready)
        else $error("second request taken while busy");

    // a new result only comes from a request being worked on
    a_result_from_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> !$past(o_in_ready))
        else $error("result appeared while engine idle");

endmodule

bind binary_lifting_lca_engine blca_checker u_blca_checker (.*);

### sim/tb_top.sv
// Self-checking testbench for binary_lifting_lca_engine: directed tree cases, a deep
// chain up to depth saturation, a back-pressure phase and random forests with queries.
// Depends on blca_pkg and the engine RTL; expected LCAs come from an in-bench tree model.
`timescale 1ns / 100ps

module tb_top;
    import blca_pkg::*;

    // ------------------------------------------------------------------
    // DUT inputs, all driven to known values from time zero
    // ------------------------------------------------------------------
    logic              i_clk      = 1'b0;
    logic              i_rst_n    = 1'b0;
    logic              i_in_valid = 1'b0;
    logic              i_req_type = 1'b0;
    logic [NODE_W-1:0] i_node_a   = '0;
    logic [NODE_W-1:0] i_node_b   = '0;
    logic              i_out_ready = 1'b0;
    wire               o_in_ready;
    wire               o_out_valid;
    wire  [NODE_W-1:0] o_common_ancestor;

    binary_lifting_lca_engine DUT (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_in_valid        (i_in_valid),
        .o_in_ready        (o_in_ready),
        .i_req_type        (i_req_type),
        .i_node_a          (i_node_a),
        .i_node_b          (i_node_b),
        .o_out_valid       (o_out_valid),
        .i_out_ready       (i_out_ready),
        .o_common_ancestor (o_common_ancestor)
    );

    // 4 ns clock
    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Tree model: ancestor rows and depths, cleared like the DUT tables
    // ------------------------------------------------------------------
    logic [NODE_W-1:0] lift_tbl [NODE_COUNT][LEVELS];
    logic [DEP_W-1:0]  depth_of [NODE_COUNT];

    logic [NODE_W-1:0] lca_expected [$];   // pending query answers, oldest first
    int                items_sent  = 0;
    int                mismatches  = 0;

    // idle control shared by the test tasks and the two handshake sides
    bit                in_burst    = 1'b0; // sender offers back to back
    bit                out_burst   = 1'b0; // receiver never drops ready
    int                hold_len    = 0;    // one-shot long receiver stall, in cycles

    function automatic void clear_tree_model();
        for (int n = 0; n < NODE_COUNT; n++) begin
            depth_of[n] = '0;
            for (int k = 0; k < LEVELS; k++) begin
                lift_tbl[n][k] = '0;
            end
        end
    endfunction

    // Attach: row built level by level from rows already stored. Node 0 stays
    // untouched so the sentinel keeps pointing at itself. Depth saturates.
    function automatic void tree_attach(input logic [NODE_W-1:0] child,
                                        input logic [NODE_W-1:0] parent);
        logic [DEP_W-1:0] d;
        if (child == '0) return;
        lift_tbl[child][0] = parent;
        for (int k = 1; k < LEVELS; k++) begin
            lift_tbl[child][k] = lift_tbl[lift_tbl[child][k-1]][k-1];
        end
        if (parent == '0) begin
            d = '0;
        end else begin
            d = depth_of[parent];          // read before the child's depth is written
            if (d < DEP_W'(NODE_COUNT - 1)) d = d + 1'b1;
        end
        depth_of[child] = d;
    endfunction

    // Query: lift the deeper node to equal depth, then both while ancestors differ.
    function automatic logic [NODE_W-1:0] lca_of(input logic [NODE_W-1:0] a,
                                                 input logic [NODE_W-1:0] b);
        logic [NODE_W-1:0] t;
        logic [NODE_W-1:0] pa;
        logic [NODE_W-1:0] pb;
        logic [DEP_W-1:0]  diff;
        if (depth_of[a] < depth_of[b]) begin
            t = a;
            a = b;
            b = t;
        end
        diff = depth_of[a] - depth_of[b];
        for (int k = LEVELS - 1; k >= 0; k--) begin
            if (diff[k]) a = lift_tbl[a][k];
        end
        if (a == b) return a;
        for (int k = LEVELS - 1; k >= 0; k--) begin
            pa = lift_tbl[a][k];
            pb = lift_tbl[b][k];
            if (pa != pb) begin
                a = pa;
                b = pb;
            end
        end
        return lift_tbl[a][0];
    endfunction

    // ------------------------------------------------------------------
    // Sender: one transaction per call. Valid stays high after acceptance
    // until the next call either replaces the payload or lowers it.
    // ------------------------------------------------------------------
    task automatic send_item(input t_req kind, input logic [NODE_W-1:0] a,
                             input logic [NODE_W-1:0] b);
        int gap;
        gap = in_burst ? 0 : $urandom_range(0, 19);
        @(negedge i_clk);
        if (gap > 0) begin
            i_in_valid = 1'b0;
            repeat (gap - 1) @(negedge i_clk);
            @(negedge i_clk);
        end
        i_req_type = kind;
        i_node_a   = a;
        i_node_b   = b;
        i_in_valid = 1'b1;
        do @(posedge i_clk); while (!o_in_ready);
        // accepted at this edge: update the model in acceptance order
        if (kind == REQ_QUERY) begin
            lca_expected.insert(lca_expected.size(), lca_of(a, b));
        end else begin
            tree_attach(a, b);
        end
        items_sent++;
    endtask

    // Sender pause: drop valid and wait for every outstanding answer.
    task automatic drain_results();
        @(negedge i_clk);
        i_in_valid = 1'b0;
        while (lca_expected.size() != 0) @(posedge i_clk);
    endtask

    // ------------------------------------------------------------------
    // Receiver: random gap before each result, plus an optional long hold
    // ------------------------------------------------------------------
    initial begin
        int gap;
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            if (hold_len > 0) begin
                gap      = hold_len;
                hold_len = 0;
            end else begin
                gap = out_burst ? 0 : $urandom_range(0, 19);
            end
            if (gap > 0) begin
                @(negedge i_clk);
                i_out_ready = 1'b0;
                repeat (gap - 1) @(negedge i_clk);
            end
            @(negedge i_clk);
            i_out_ready = 1'b1;
            do @(posedge i_clk); while (!o_out_valid);
        end
    end

    // ------------------------------------------------------------------
    // Result checker: each accepted transaction against the oldest answer
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        logic [NODE_W-1:0] want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (lca_expected.size() == 0) begin
                if (mismatches < 10)
                    $display("[%0t] unexpected result: got %0d", $realtime, o_common_ancestor);
                mismatches++;
            end else begin
                want = lca_expected.pop_front();
                if (o_common_ancestor !== want) begin
                    if (mismatches < 10)
                        $display("[%0t] lca mismatch: expected %0d, got %0d",
                                 $realtime, want, o_common_ancestor);
                    mismatches++;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Test tasks
    // ------------------------------------------------------------------

    // Small hand-built tree covering the corner cases of attach and query.
    task automatic test_directed_cases();
        send_item(REQ_ATTACH, 10'd1,    10'd0);     // root
        send_item(REQ_ATTACH, 10'd0,    10'd5);     // sentinel attach, ignored
        send_item(REQ_QUERY,  10'd0,    10'd0);
        send_item(REQ_QUERY,  10'd1023, 10'd1);     // never attached node
        send_item(REQ_ATTACH, 10'd2,    10'd1);
        send_item(REQ_ATTACH, 10'd3,    10'd1);
        send_item(REQ_ATTACH, 10'd4,    10'd2);
        send_item(REQ_ATTACH, 10'd1023, 10'd4);     // top node number
        send_item(REQ_QUERY,  10'd4,    10'd3);
        send_item(REQ_QUERY,  10'd1023, 10'd3);
        send_item(REQ_QUERY,  10'd3,    10'd1023);  // swapped operands
        send_item(REQ_QUERY,  10'd1023, 10'd1023);  // same node
        send_item(REQ_QUERY,  10'd2,    10'd1023);  // one is ancestor of the other
        send_item(REQ_ATTACH, 10'd5,    10'd600);   // parent not yet attached
        send_item(REQ_QUERY,  10'd5,    10'd600);
        send_item(REQ_ATTACH, 10'd2,    10'd3);     // re-attach, children keep stale rows
        send_item(REQ_QUERY,  10'd4,    10'd3);
        send_item(REQ_QUERY,  10'd1023, 10'd0);
        send_item(REQ_QUERY,  10'd0,    10'd1023);
        send_item(REQ_ATTACH, 10'd1022, 10'd0);     // second root, disjoint tree
        send_item(REQ_QUERY,  10'd1022, 10'd4);
        send_item(REQ_ATTACH, 10'd682,  10'd341);   // alternating bit patterns
        send_item(REQ_QUERY,  10'd341,  10'd682);
        drain_results();
    endtask

    // One long chain over every node, then a loop back to push depth into
    // saturation; queries spread over the chain use every lift level.
    task automatic test_deep_chain();
        logic [NODE_W-1:0] a;
        logic [NODE_W-1:0] b;
        for (int n = 1; n < NODE_COUNT; n++) begin
            in_burst = (n < 512);
            send_item(REQ_ATTACH, NODE_W'(n), NODE_W'(n - 1));
            if (n % 29 == 0) begin
                a = NODE_W'($urandom_range(1, n));
                b = NODE_W'($urandom_range(1, n));
                send_item(REQ_QUERY, a, b);
            end
        end
        in_burst = 1'b0;
        send_item(REQ_QUERY,  10'd1023, 10'd1);     // full-depth gap
        send_item(REQ_ATTACH, 10'd1,    10'd1023);  // depth reaches the ceiling
        send_item(REQ_ATTACH, 10'd2,    10'd1);     // saturates
        send_item(REQ_ATTACH, 10'd3,    10'd2);
        send_item(REQ_QUERY,  10'd3,    10'd500);
        send_item(REQ_QUERY,  10'd2,    10'd1);
        send_item(REQ_QUERY,  10'd1023, 10'd3);
        send_item(REQ_QUERY,  10'd700,  10'd3);
        drain_results();
    endtask

    // Receiver stalls for a long stretch while the sender keeps offering
    // queries back to back, so the engine backs up into its input.
    task automatic test_backpressure();
        hold_len = 600;
        in_burst = 1'b1;
        repeat (40) begin
            send_item(REQ_QUERY, NODE_W'($urandom_range(0, 1023)),
                      NODE_W'($urandom_range(0, 1023)));
        end
        in_burst = 1'b0;
        drain_results();
    endtask

    // Random trees built parent-first with queries among their members,
    // plus some noise: stray attaches and queries, sentinel attaches, re-attaches.
    task automatic test_random_forest(input int target);
        logic [NODE_W-1:0] members [$];
        logic [NODE_W-1:0] node;
        logic [NODE_W-1:0] par;
        int                tree_size;
        int                round;
        round = 0;
        while (items_sent < target) begin
            round++;
            in_burst  = (round % 5 == 3);
            out_burst = (round % 7 == 2) || (round % 5 == 3);
            members.delete();
            tree_size = $urandom_range(2, 40);
            node = NODE_W'($urandom_range(1, 1023));
            send_item(REQ_ATTACH, node, 10'd0);
            members.insert(members.size(), node);
            for (int i = 1; i < tree_size; i++) begin
                node = NODE_W'($urandom_range(1, 1023));
                // bias toward the newest member so some trees grow deep
                if ($urandom_range(0, 3) == 0)
                    par = members[members.size() - 1];
                else
                    par = members[$urandom_range(0, members.size() - 1)];
                send_item(REQ_ATTACH, node, par);
                members.insert(members.size(), node);
            end
            repeat (tree_size) begin
                send_item(REQ_QUERY, members[$urandom_range(0, members.size() - 1)],
                          members[$urandom_range(0, members.size() - 1)]);
            end
            repeat ($urandom_range(0, 4)) begin
                case ($urandom_range(0, 3))
                    0: send_item(REQ_ATTACH, NODE_W'($urandom_range(0, 1023)),
                                 NODE_W'($urandom_range(0, 1023)));
                    1: send_item(REQ_ATTACH, 10'd0, NODE_W'($urandom_range(0, 1023)));
                    2: send_item(REQ_QUERY, NODE_W'($urandom_range(0, 1023)),
                                 NODE_W'($urandom_range(0, 1023)));
                    default: send_item(REQ_ATTACH,
                                       members[$urandom_range(0, members.size() - 1)],
                                       members[$urandom_range(0, members.size() - 1)]);
                endcase
            end
        end
        in_burst  = 1'b0;
        out_burst = 1'b0;
    endtask

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial begin
        clear_tree_model();
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;
        // the clearing pass after reset is covered by waiting on in_ready

        test_directed_cases();
        test_deep_chain();
        test_backpressure();
        test_random_forest(1900);

        drain_results();
        repeat (60) @(posedge i_clk);   // room for a stray late result
        if (mismatches == 0 && lca_expected.size() == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

    // Run limit, several times the slowest legal run
    initial begin
        #4000000;
        $display("Some tests failed");
        $finish;
    end

endmodule

### files.f
rtl/blca_pkg.sv
rtl/blca_ram.sv
rtl/blca_core.sv
rtl/binary_lifting_lca_engine.sv
rtl/blca_checker.sv
sim/tb_top.sv
